>>> rtl/core/wsts_pkg.sv
// Package with shared types and constants for the work-stealing task scheduler.
`default_nettype none
package wsts_pkg;
  localparam int MaxWorkers = 8;
  localparam int QueueDepth = 16;
  localparam int TaskIdBits = 16;
  localparam int WBits = $clog2(MaxWorkers);
  localparam int SBits = $clog2(QueueDepth);
  localparam int FBits = $clog2(QueueDepth + 1);
  localparam int ABits = WBits + SBits;

  typedef enum logic [1:0] {
    OP_SUBMIT = 2'd0,
    OP_BATCH = 2'd1,
    OP_FETCH = 2'd2,
    OP_DONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_DISABLED = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  localparam logic REG_NUM_WORKERS = 1'b0;
  localparam logic REG_ENABLE = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_SCAN, S_READ, S_WAIT, S_OUT
  } state_t;

  typedef struct packed {
    logic [1:0] op;
    logic [15:0] task_id;
    logic [2:0] worker_id;
    logic [7:0] batch_count;
  } req_t;

  typedef struct packed {
    logic granted;
    logic [15:0] task_out;
    logic stolen;
    logic [2:0] source_queue;
    logic [15:0] pending_count;
    logic all_done;
    logic [1:0] status;
  } rsp_t;
endpackage
`default_nettype wire

>>> rtl/core/wsts_if.sv
// Valid/ready channel interface carrying one payload.
`default_nettype none
interface wsts_if #(parameter type payload_t = logic);
  logic valid;
  logic ready;
  payload_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/work_stealing_task_scheduler.sv
// Top level of the work-stealing task scheduler.
//
//   channel | dir | payload
//   req     | in  | op, task_id, worker_id, batch_count
//   rsp     | out | granted, task_out, stolen, source_queue, pending_count,
//           |     | all_done, status
//   cfg     | in  | cfg_we, cfg_index, cfg_data
//
// A submit or complete passes through S_DIV and S_OUT; a fetch of the own queue
// also passes through S_READ and S_WAIT, a steal adds S_SCAN, which looks at up to
// nw-1 other queues, one queue per cycle, and the first item of a batch stays in
// S_DIV for the serial divider: one step to load it and eight for the quotient bits.
// Synchronous active-high reset empties all queues; no clearing pass runs.
// The request side accepts one item at a time and stalls while the result
// register is full and not yet taken.
`default_nettype none
module work_stealing_task_scheduler (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [3:0] cfg_data,
  wsts_if.sink req,
  wsts_if.source rsp
);
  import wsts_pkg::*;

  state_t state, state_next;
  req_t r;
  logic [3:0] num_workers;
  logic enable;
  logic [SBits-1:0] queue_head [MaxWorkers];
  logic [FBits-1:0] queue_fill [MaxWorkers];
  logic [WBits-1:0] next_queue, batch_queue;
  logic [15:0] pending_tasks;
  logic [7:0] batch_left, chunk_size, chunk_used;
  // Serial divider state: quotient/remainder of (bc-1)/nw, plus one gives ceil(bc/nw).
  logic [7:0] dq;
  logic [3:0] drem;
  logic [3:0] dcnt;
  logic [WBits-1:0] victim;
  logic [3:0] scan_left;
  rsp_t res;
  logic out_valid;

  logic we;
  logic [ABits-1:0] waddr, raddr;
  logic [TaskIdBits-1:0] rdata;

  wsts_store u_store (.clk, .we, .waddr, .wdata(r.task_id), .raddr, .rdata);

  // Effective worker count, clamped to 1..MaxWorkers.
  logic [3:0] nw;
  always_comb begin
    nw = num_workers;
    if (nw == 4'd0) nw = 4'd1;
    if (nw > 4'(MaxWorkers)) nw = 4'(MaxWorkers);
  end

  // Reduces v modulo n by conditional subtraction of 8n, 4n, 2n and n. The
  // stored queue pointers may exceed the worker count after it is lowered.
  function automatic logic [WBits-1:0] wrap(input logic [3:0] v, input logic [3:0] n);
    logic [6:0] t;
    t = {3'b000, v};
    if (t >= {n, 3'b000}) t = t - {n, 3'b000};
    if (t >= {1'b0, n, 2'b00}) t = t - {1'b0, n, 2'b00};
    if (t >= {2'b00, n, 1'b0}) t = t - {2'b00, n, 1'b0};
    if (t >= {3'b000, n}) t = t - {3'b000, n};
    return t[WBits-1:0];
  endfunction

  logic [WBits-1:0] nq_mod, bq_mod, next_v, own;
  logic [2:0] ins_q;
  logic full_q;
  logic [7:0] bc_eff;
  assign nq_mod = wrap({1'b0, next_queue}, nw);
  assign bq_mod = wrap({1'b0, batch_queue}, nw);
  assign own = r.worker_id[WBits-1:0];
  assign next_v = wrap({1'b0, victim} + 4'd1, nw);
  assign ins_q = (r.op == OP_SUBMIT) ? nq_mod : bq_mod;
  assign full_q = queue_fill[ins_q] >= FBits'(QueueDepth);
  assign bc_eff = (r.batch_count == 8'd0) ? 8'd1 : r.batch_count;

  assign req.ready = (state == S_IDLE) && !out_valid;
  assign rsp.valid = out_valid;
  assign rsp.data = res;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (req.valid && req.ready) state_next = S_DIV;
      S_DIV: begin
        state_next = S_OUT;
        // The opening item of a batch stays here until the chunk size is known.
        if (r.op == OP_BATCH && enable && batch_left == 8'd0) state_next = S_DIV;
        else if (r.op == OP_FETCH && {1'b0, r.worker_id} < nw)
          state_next = (queue_fill[own] != '0) ? S_READ : S_SCAN;
      end
      S_SCAN: begin
        if (scan_left == 4'd0) state_next = S_OUT;
        else if (queue_fill[victim] != '0) state_next = S_READ;
      end
      S_READ: state_next = S_WAIT;
      S_WAIT: state_next = S_OUT;
      S_OUT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    we = 1'b0;
    waddr = {ins_q, SBits'(queue_head[ins_q] + SBits'(queue_fill[ins_q]))};
    raddr = {victim, SBits'(queue_head[victim] + ((r.op == OP_FETCH && !res.stolen) ?
             SBits'(queue_fill[victim] - 1'b1) : SBits'(0)))};
    if (state == S_DIV && (r.op == OP_SUBMIT || r.op == OP_BATCH) && enable && !full_q &&
        !(r.op == OP_BATCH && batch_left == 8'd0) && !(r.op == OP_BATCH && dcnt != 4'd0))
      we = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      num_workers <= 4'd8;
      enable <= 1'b1;
      next_queue <= '0; batch_queue <= '0;
      pending_tasks <= '0;
      batch_left <= '0; chunk_size <= '0; chunk_used <= '0;
      dcnt <= '0;
      for (int i = 0; i < MaxWorkers; i++) begin
        queue_head[i] <= '0;
        queue_fill[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_NUM_WORKERS) num_workers <= cfg_data;
        else enable <= cfg_data[0];
      end
      if (rsp.valid && rsp.ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            r <= req.data;
            dcnt <= '0;
            res <= '0;
          end
        end
        S_DIV: begin
          unique case (op_t'(r.op))
            OP_SUBMIT: begin
              if (!enable) res.status <= ST_DISABLED;
              else begin
                next_queue <= wrap({1'b0, nq_mod} + 4'd1, nw);
                res.source_queue <= nq_mod;
                if (full_q) res.status <= ST_FULL;
                else begin
                  queue_fill[nq_mod] <= queue_fill[nq_mod] + 1'b1;
                  if (pending_tasks != 16'hFFFF) pending_tasks <= pending_tasks + 1'b1;
                end
              end
            end
            OP_BATCH: begin
              if (!enable) res.status <= ST_DISABLED;
              else if (batch_left == 8'd0) begin
                // Restoring divider: one quotient bit of (bc-1)/nw a cycle.
                if (dcnt == 4'd0) begin
                  dq <= bc_eff - 8'd1;
                  drem <= '0;
                  dcnt <= 4'd1;
                end else begin
                  logic [4:0] trial;
                  trial = {drem, dq[7]};
                  if (trial >= {1'b0, nw}) begin
                    drem <= 4'(trial - {1'b0, nw});
                    dq <= {dq[6:0], 1'b1};
                  end else begin
                    drem <= trial[3:0];
                    dq <= {dq[6:0], 1'b0};
                  end
                  if (dcnt == 4'd8) begin
                    chunk_size <= ((trial >= {1'b0, nw}) ? {dq[6:0], 1'b1} :
                                   {dq[6:0], 1'b0}) + 8'd1;
                    batch_left <= bc_eff;
                    chunk_used <= '0;
                    batch_queue <= '0;
                    dcnt <= '0;
                  end else dcnt <= dcnt + 1'b1;
                end
              end else begin
                res.source_queue <= bq_mod;
                if (full_q) res.status <= ST_FULL;
                else begin
                  queue_fill[bq_mod] <= queue_fill[bq_mod] + 1'b1;
                  if (pending_tasks != 16'hFFFF) pending_tasks <= pending_tasks + 1'b1;
                end
                if (chunk_used + 8'd1 >= chunk_size) begin
                  chunk_used <= '0;
                  batch_queue <= wrap({1'b0, bq_mod} + 4'd1, nw);
                end else chunk_used <= chunk_used + 8'd1;
                batch_left <= batch_left - 8'd1;
              end
            end
            OP_FETCH: begin
              if ({1'b0, r.worker_id} < nw) begin
                scan_left <= nw - 4'd1;
                if (queue_fill[own] != '0) victim <= own;
                else begin
                  res.stolen <= 1'b1;
                  victim <= wrap({1'b0, own} + 4'd1, nw);
                end
              end
            end
            OP_DONE: begin
              if (pending_tasks != 16'd0) begin
                pending_tasks <= pending_tasks - 1'b1;
                res.all_done <= (pending_tasks == 16'd1);
              end
            end
            default: ;
          endcase
        end
        S_SCAN: begin
          if (scan_left != 4'd0 && queue_fill[victim] == '0) begin
            victim <= next_v;
            scan_left <= scan_left - 1'b1;
          end
        end
        S_READ: begin
          // Address is presented now; data arrives next cycle.
          queue_fill[victim] <= queue_fill[victim] - 1'b1;
          if (res.stolen) queue_head[victim] <= queue_head[victim] + 1'b1;
        end
        S_WAIT: begin
          res.granted <= 1'b1;
          res.task_out <= rdata;
          res.source_queue <= victim;
        end
        S_OUT: begin
          if (!res.granted) res.stolen <= 1'b0;
          res.pending_count <= pending_tasks;
          out_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/wsts_store.sv
// Task storage memory with one write and one registered read port.
`default_nettype none
module wsts_store (
  input  logic clk,
  input  logic we,
  input  logic [wsts_pkg::ABits-1:0] waddr,
  input  logic [wsts_pkg::TaskIdBits-1:0] wdata,
  input  logic [wsts_pkg::ABits-1:0] raddr,
  output logic [wsts_pkg::TaskIdBits-1:0] rdata
);
  import wsts_pkg::*;
  logic [TaskIdBits-1:0] mem [MaxWorkers*QueueDepth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> rtl/core/wsts_checker.sv
// Port-level checker for the scheduler, bound to the top level.
`default_nettype none
module wsts_checker (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input logic granted,
  input logic stolen,
  input logic all_done,
  input logic [15:0] pending_count,
  input logic [15:0] task_out
);
  a_stall: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
  a_stolen: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && stolen |-> granted) else $error("stolen without grant");
  a_done: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && all_done |-> pending_count == 16'd0) else $error("done with work");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !req_ready) else $error("accepting while result held");
  a_idgrant: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !granted |-> task_out == 16'd0) else $error("task without grant");
endmodule

bind work_stealing_task_scheduler wsts_checker u_chk (
  .clk, .rst, .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .granted(rsp.data.granted),
  .stolen(rsp.data.stolen), .all_done(rsp.data.all_done),
  .pending_count(rsp.data.pending_count), .task_out(rsp.data.task_out)
);
`default_nettype wire

>>> bench/tb_top.sv
// Self-checking testbench for the work-stealing task scheduler.
`timescale 1ns / 1ps
module tb_top;
  import wsts_pkg::*;

  localparam int CycleLimit = 400000;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_index;
  logic [3:0] cfg_data;

  wsts_if #(.payload_t(req_t)) req_ch ();
  wsts_if #(.payload_t(rsp_t)) rsp_ch ();

  work_stealing_task_scheduler dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Shadow copy of the scheduler: per-queue storage, ring heads and fill levels,
  // the round-robin pointer, the pending counter and the open batch position.
  logic [15:0] shadow_store [MaxWorkers * QueueDepth];
  int shadow_head [MaxWorkers];
  int shadow_fill [MaxWorkers];
  int rr_next, pending_shadow;
  int batch_left, chunk_size, chunk_used, batch_queue;
  int cfg_workers, cfg_en;

  // Results still owed by the block, oldest first.
  rsp_t rsp_expected [$];

  int errors = 0;
  int delivered = 0;
  int cycles = 0;
  int accepted;
  int send_idle_pct, recv_stall_pct;

  // Directed rows carry a typed-in result only where it is obvious.
  typedef struct {
    req_t r;
    bit fixed;
    rsp_t f;
  } row_t;
  row_t dir_rows [$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit shadow_push(int q, logic [15:0] id);
    if (shadow_fill[q] >= QueueDepth) return 1'b0;
    shadow_store[q * QueueDepth + (shadow_head[q] + shadow_fill[q]) % QueueDepth] = id;
    shadow_fill[q]++;
    return 1'b1;
  endfunction

  function automatic int eff_workers();
    if (cfg_workers < 1) return 1;
    if (cfg_workers > MaxWorkers) return MaxWorkers;
    return cfg_workers;
  endfunction

  // Advances the shadow state by one request and returns the result it must cause.
  function automatic rsp_t sched_predict(req_t r);
    rsp_t o;
    int nw, q, v, bc;
    o = '0;
    nw = eff_workers();
    case (r.op)
      OP_SUBMIT: begin
        if (cfg_en == 0) begin
          o.status = ST_DISABLED;
        end else begin
          q = rr_next % nw;
          rr_next = (q + 1) % nw;
          o.source_queue = 3'(q);
          if (shadow_push(q, r.task_id)) begin
            if (pending_shadow < 65535) pending_shadow++;
          end else begin
            o.status = ST_FULL;
          end
        end
      end
      OP_BATCH: begin
        if (cfg_en == 0) begin
          o.status = ST_DISABLED;
        end else begin
          // The count is only read by the item that opens a batch.
          if (batch_left == 0) begin
            bc = (r.batch_count == 0) ? 1 : r.batch_count;
            batch_left = bc;
            chunk_size = (bc + nw - 1) / nw;
            chunk_used = 0;
            batch_queue = 0;
          end
          q = batch_queue % nw;
          o.source_queue = 3'(q);
          if (shadow_push(q, r.task_id)) begin
            if (pending_shadow < 65535) pending_shadow++;
          end else begin
            o.status = ST_FULL;
          end
          chunk_used++;
          if (chunk_used >= chunk_size) begin
            chunk_used = 0;
            batch_queue = (q + 1) % nw;
          end
          batch_left--;
        end
      end
      OP_FETCH: begin
        if (r.worker_id < nw) begin
          if (shadow_fill[r.worker_id] > 0) begin
            // Own queue: take the newest entry from the back.
            q = r.worker_id;
            o.task_out = shadow_store[q * QueueDepth +
                                      (shadow_head[q] + shadow_fill[q] - 1) % QueueDepth];
            shadow_fill[q]--;
            o.granted = 1'b1;
            o.source_queue = 3'(q);
          end else begin
            // Steal the oldest entry of the first non-empty queue after this one.
            for (int i = 0; i + 1 < nw; i++) begin
              v = (r.worker_id + 1 + i) % nw;
              if (v != r.worker_id && shadow_fill[v] > 0) begin
                o.task_out = shadow_store[v * QueueDepth + shadow_head[v]];
                shadow_head[v] = (shadow_head[v] + 1) % QueueDepth;
                shadow_fill[v]--;
                o.granted = 1'b1;
                o.stolen = 1'b1;
                o.source_queue = 3'(v);
                break;
              end
            end
          end
        end
      end
      default: begin
        if (pending_shadow > 0) begin
          pending_shadow--;
          if (pending_shadow == 0) o.all_done = 1'b1;
        end
      end
    endcase
    o.pending_count = 16'(pending_shadow);
    return o;
  endfunction

  function automatic req_t mk_req(op_t op, logic [15:0] id, logic [2:0] w, logic [7:0] bc);
    req_t r;
    r.op = op;
    r.task_id = id;
    r.worker_id = w;
    r.batch_count = bc;
    return r;
  endfunction

  function automatic rsp_t mk_rsp(logic g, logic [15:0] t, logic s, logic [2:0] q,
                                  logic [15:0] p, logic d, status_t st);
    rsp_t o;
    o.granted = g;
    o.task_out = t;
    o.stolen = s;
    o.source_queue = q;
    o.pending_count = p;
    o.all_done = d;
    o.status = st;
    return o;
  endfunction

  task automatic add_row(req_t r, bit fixed = 1'b0, rsp_t f = '0);
    row_t row;
    row.r = r;
    row.fixed = fixed;
    row.f = f;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  // Called right after a rising edge. Holds the request until its transfer and
  // records the expected result; valid stays high so the next call may reuse it.
  task automatic send_req(req_t r, bit fixed, rsp_t f);
    rsp_t p;
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= r;
    do @(posedge clk); while (!req_ch.ready);
    p = sched_predict(r);
    rsp_expected.insert(rsp_expected.size(), fixed ? f : p);
    accepted++;
  endtask

  // Register writes only happen with the block idle and nothing owed.
  task automatic write_reg(logic idx, logic [3:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == REG_NUM_WORKERS) cfg_workers = val;
    else cfg_en = val[0];
  endtask

  task automatic drain_and_settle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (rsp_expected.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // Random requests, biased so that open batches are mostly carried on and
  // queues both fill up and drain.
  function automatic req_t rand_req(int fetch_pct);
    int pick;
    logic [7:0] bc;
    pick = $urandom_range(99);
    if (pick < 4) bc = 8'd0;
    else if (pick < 30) bc = 8'($urandom_range(255, 1));
    else bc = 8'($urandom_range(12, 1));
    if (batch_left > 0 && $urandom_range(99) < 80)
      return mk_req(OP_BATCH, 16'($urandom), 3'($urandom), bc);
    pick = $urandom_range(99);
    if (pick < fetch_pct)
      return mk_req(OP_FETCH, 16'($urandom), 3'($urandom), 8'($urandom));
    pick = $urandom_range(99);
    if (pick < 45) return mk_req(OP_SUBMIT, 16'($urandom), 3'($urandom), 8'($urandom));
    if (pick < 70) return mk_req(OP_BATCH, 16'($urandom), 3'($urandom), bc);
    return mk_req(OP_DONE, 16'($urandom), 3'($urandom), 8'($urandom));
  endfunction

  task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: mismatch on %s, expected %0h, actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // Result side: random back-pressure and comparison on every transfer.
  always @(posedge clk) begin
    rsp_t exp_r;
    rsp_t act_r;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        act_r = rsp_ch.data;
        delivered++;
        if (rsp_expected.size() == 0) begin
          $display("%0t: unexpected result, actual %0h", $time, act_r);
          errors++;
        end else begin
          exp_r = rsp_expected[0];
          rsp_expected.delete(0);
          check_field("granted", exp_r.granted, act_r.granted);
          check_field("task_out", exp_r.task_out, act_r.task_out);
          check_field("stolen", exp_r.stolen, act_r.stolen);
          check_field("source_queue", exp_r.source_queue, act_r.source_queue);
          check_field("pending_count", exp_r.pending_count, act_r.pending_count);
          check_field("all_done", exp_r.all_done, act_r.all_done);
          check_field("status", exp_r.status, act_r.status);
        end
      end
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAIL work_stealing_task_scheduler");
      $finish;
    end
  end

  typedef struct {
    int nw;
    int en;
    int send_pct;
    int recv_pct;
    int items;
    int fetch_pct;
  } phase_t;

  initial begin
    phase_t phases [8];
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = 1'b0;
    cfg_data = 4'd0;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    accepted = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    foreach (shadow_head[i]) begin
      shadow_head[i] = 0;
      shadow_fill[i] = 0;
    end
    rr_next = 0;
    pending_shadow = 0;
    batch_left = 0;
    chunk_size = 0;
    chunk_used = 0;
    batch_queue = 0;
    cfg_workers = 8;
    cfg_en = 1;

    // Directed part, from reset with eight workers enabled.
    add_row(mk_req(OP_FETCH, 16'h0000, 3'd0, 8'd0), 1'b1,
            mk_rsp(0, 16'h0, 0, 3'd0, 16'd0, 0, ST_OK));
    add_row(mk_req(OP_DONE, 16'h0000, 3'd0, 8'd0), 1'b1,
            mk_rsp(0, 16'h0, 0, 3'd0, 16'd0, 0, ST_OK));
    add_row(mk_req(OP_SUBMIT, 16'hFFFF, 3'd7, 8'hFF), 1'b1,
            mk_rsp(0, 16'h0, 0, 3'd0, 16'd1, 0, ST_OK));
    add_row(mk_req(OP_SUBMIT, 16'h0000, 3'd0, 8'd0), 1'b1,
            mk_rsp(0, 16'h0, 0, 3'd1, 16'd2, 0, ST_OK));
    add_row(mk_req(OP_FETCH, 16'h0, 3'd0, 8'd0), 1'b1,
            mk_rsp(1, 16'hFFFF, 0, 3'd0, 16'd2, 0, ST_OK));
    add_row(mk_req(OP_FETCH, 16'h0, 3'd0, 8'd0), 1'b1,
            mk_rsp(1, 16'h0000, 1, 3'd1, 16'd2, 0, ST_OK));
    add_row(mk_req(OP_DONE, 16'h0, 3'd0, 8'd0), 1'b1,
            mk_rsp(0, 16'h0, 0, 3'd0, 16'd1, 0, ST_OK));
    add_row(mk_req(OP_DONE, 16'h0, 3'd0, 8'd0), 1'b1,
            mk_rsp(0, 16'h0, 0, 3'd0, 16'd0, 1, ST_OK));
    add_row(mk_req(OP_DONE, 16'h0, 3'd0, 8'd0), 1'b1,
            mk_rsp(0, 16'h0, 0, 3'd0, 16'd0, 0, ST_OK));
    // A batch count of zero behaves as a batch of one.
    add_row(mk_req(OP_BATCH, 16'h1234, 3'd0, 8'd0));
    // A three-task batch spreads one task per queue.
    add_row(mk_req(OP_BATCH, 16'hA001, 3'd0, 8'd3));
    add_row(mk_req(OP_BATCH, 16'hA002, 3'd0, 8'd0));
    add_row(mk_req(OP_BATCH, 16'hA003, 3'd0, 8'd0));
    // A plain submit in the middle of an open batch leaves the batch alone.
    add_row(mk_req(OP_BATCH, 16'hB001, 3'd0, 8'd12));
    add_row(mk_req(OP_SUBMIT, 16'h5555, 3'd0, 8'd0));
    add_row(mk_req(OP_BATCH, 16'hB002, 3'd0, 8'd0));
    add_row(mk_req(OP_BATCH, 16'hB003, 3'd0, 8'd0));
    add_row(mk_req(OP_BATCH, 16'hB004, 3'd0, 8'd0));
    // Steals that wrap past the last worker, then own-queue pops.
    add_row(mk_req(OP_FETCH, 16'h0, 3'd7, 8'd0));
    add_row(mk_req(OP_FETCH, 16'h0, 3'd6, 8'd0));
    add_row(mk_req(OP_FETCH, 16'h0, 3'd1, 8'd0));
    add_row(mk_req(OP_FETCH, 16'h0, 3'd2, 8'd0));
    add_row(mk_req(OP_DONE, 16'hFFFF, 3'd7, 8'hFF));

    // nw, enable, sender idle %, receiver stall %, items, fetch %
    phases[0] = '{8, 1, 0, 0, 110, 35};
    phases[1] = '{1, 1, 45, 0, 100, 25};
    phases[2] = '{3, 1, 0, 45, 100, 30};
    phases[3] = '{8, 0, 37, 37, 60, 40};
    phases[4] = '{15, 1, 37, 37, 100, 35};
    phases[5] = '{0, 1, 0, 0, 80, 25};
    phases[6] = '{5, 1, 45, 0, 100, 35};
    phases[7] = '{2, 1, 0, 45, 100, 30};

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) send_req(dir_rows[i].r, dir_rows[i].fixed, dir_rows[i].f);
    drain_and_settle();

    foreach (phases[p]) begin
      write_reg(REG_NUM_WORKERS, 4'(phases[p].nw));
      write_reg(REG_ENABLE, 4'(phases[p].en));
      cfg_we <= 1'b0;
      send_idle_pct = phases[p].send_pct;
      recv_stall_pct = phases[p].recv_pct;
      repeat (phases[p].items) send_req(rand_req(phases[p].fetch_pct), 1'b0, '0);
      drain_and_settle();
    end

    $display("Ran %0d requests and checked %0d results over %0d cycles,", accepted,
             delivered, cycles);
    $display("across worker counts 0..15, with pool disabled once, under gaps and stalls.");
    if (errors == 0 && rsp_expected.size() == 0) begin
      $display("PASS work_stealing_task_scheduler");
    end else begin
      $display("FAIL work_stealing_task_scheduler");
    end
    $finish;
  end
endmodule
